>>> rtl/core/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the sensor point rotator
// Field widths, fixed-point formats, register indexes and the CORDIC
// arctangent steps used by the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

   // Field widths
   localparam int COORD_W  = 20;  // lat/long, metres Q.6
   localparam int ANG_W    = 15;  // angle register, degrees Q.6
   localparam int RADAR_W  = 3;   // one-based radar number
   localparam int SEL_W    = 2;   // selected radar register
   localparam int GUARD    = 8;   // guard bits in the rotator
   localparam int CW       = 31;  // rotator coordinate width
   localparam int ZW       = 25;  // residual angle width, 2^-16 degree
   localparam int RA_W     = 16;  // reduced angle width, degrees Q.6
   localparam int GAIN_W   = 17;  // signed width of the gain constant
   localparam int PROD_W   = CW + GAIN_W;
   localparam int ROUND_SH = 24;

   // Parameter defaults and limits
   localparam int NUM_RADARS_DEF      = 4;
   localparam int ROTATION_STAGES_DEF = 16;
   localparam int MAX_STAGES          = 24;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = ANG_W;
   localparam logic [CSR_AW-1:0] CSR_SELECTED = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_ANGLE_A  = 3'd1;

   // Angle constants, degrees Q.6
   localparam logic signed [RA_W-1:0] ANG_FULL    = 16'sd23040;
   localparam logic signed [RA_W-1:0] ANG_HALF    = 16'sd11520;
   localparam logic signed [RA_W-1:0] ANG_QUARTER = 16'sd5760;

   // 1/K in Q0.16
   localparam logic signed [GAIN_W-1:0] INV_GAIN = 17'sd39797;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sd524287;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -20'sd524288;

   // Point state inside the rotator
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } point_type;

   // Side information that travels with each point
   typedef struct packed {
      logic [RADAR_W-1:0] radar;
      logic               last;
      logic               sel;
      logic               bypass;  // unknown radar: no rotation
   } side_type;

   // atan(2^-i) in 2^-16 degree units, rounded to nearest
   function automatic logic signed [ZW-1:0] atan_step(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = 25'sd2949120;
         1:  v = 25'sd1740967;
         2:  v = 25'sd919879;
         3:  v = 25'sd466945;
         4:  v = 25'sd234379;
         5:  v = 25'sd117304;
         6:  v = 25'sd58666;
         7:  v = 25'sd29335;
         8:  v = 25'sd14668;
         9:  v = 25'sd7334;
         10: v = 25'sd3667;
         11: v = 25'sd1833;
         12: v = 25'sd917;
         13: v = 25'sd458;
         14: v = 25'sd229;
         15: v = 25'sd115;
         16: v = 25'sd57;
         17: v = 25'sd29;
         18: v = 25'sd14;
         19: v = 25'sd7;
         20: v = 25'sd4;
         21: v = 25'sd2;
         22: v = 25'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/spr_prerot.sv
// ----------------------------------------------------------------------------
// spr_prerot: angle reduction and quadrant pre-rotation
// Brings the angle into +-90 degrees by a quarter turn of the point, widens
// the coordinates by the guard bits and scales the angle to 2^-16 degree.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_prerot import spr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      up_valid,
   output logic                           up_ready,
   input  wire logic signed [ANG_W-1:0]   up_angle,
   input  wire logic signed [COORD_W-1:0] up_lat,
   input  wire logic signed [COORD_W-1:0] up_long,
   input  wire side_type                  up_side,
   output logic                           dn_valid,
   input  wire logic                      dn_ready,
   output point_type                      dn_point,
   output side_type                       dn_side
);

   logic                      valid_ff;
   point_type                 point_ff;
   side_type                  side_ff;
   point_type                 point_in;
   logic signed [RA_W-1:0]    ang_red;
   logic signed [RA_W-1:0]    ang_q;
   logic signed [COORD_W:0]   xq;
   logic signed [COORD_W:0]   yq;

   assign up_ready = !valid_ff || dn_ready;

   // Reduce once by a full turn, then turn by a quarter if needed
   always_comb begin
      ang_red = RA_W'(up_angle);
      if (ang_red >= ANG_HALF) begin
         ang_red = ang_red - ANG_FULL;
      end else if (ang_red < -ANG_HALF) begin
         ang_red = ang_red + ANG_FULL;
      end
      xq    = (COORD_W+1)'(up_lat);
      yq    = (COORD_W+1)'(up_long);
      ang_q = ang_red;
      if (ang_red > ANG_QUARTER) begin
         xq    = -(COORD_W+1)'(up_long);
         yq    = (COORD_W+1)'(up_lat);
         ang_q = ang_red - ANG_QUARTER;
      end else if (ang_red < -ANG_QUARTER) begin
         xq    = (COORD_W+1)'(up_long);
         yq    = -(COORD_W+1)'(up_lat);
         ang_q = ang_red + ANG_QUARTER;
      end
      point_in.x = CW'(xq) <<< GUARD;
      point_in.y = CW'(yq) <<< GUARD;
      point_in.z = ZW'(ang_q) <<< 10;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         point_ff <= point_in;
         side_ff  <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_point = point_ff;
   assign dn_side  = side_ff;

endmodule

`default_nettype wire

>>> rtl/core/spr_cordic_stage.sv
// ----------------------------------------------------------------------------
// spr_cordic_stage: one registered CORDIC micro-rotation
// Turns the point by +-atan(2^-i) toward a zero residual angle. Points from
// an unknown radar pass unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_cordic_stage import spr_pkg::*; #(
   parameter int STAGE_IDX = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     up_valid,
   output logic          up_ready,
   input  wire point_type up_point,
   input  wire side_type  up_side,
   output logic          dn_valid,
   input  wire logic     dn_ready,
   output point_type     dn_point,
   output side_type      dn_side
);

   localparam logic signed [ZW-1:0] ATAN_I = atan_step(STAGE_IDX);

   logic                 valid_ff;
   point_type            point_ff;
   side_type             side_ff;
   point_type            point_in;
   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;

   assign up_ready = !valid_ff || dn_ready;

   // Micro-rotation, direction from the sign of the residual angle
   always_comb begin
      dx       = up_point.y >>> STAGE_IDX;
      dy       = up_point.x >>> STAGE_IDX;
      point_in = up_point;
      if (!up_side.bypass) begin
         if (!up_point.z[ZW-1]) begin
            point_in.x = up_point.x - dx;
            point_in.y = up_point.y + dy;
            point_in.z = up_point.z - ATAN_I;
         end else begin
            point_in.x = up_point.x + dx;
            point_in.y = up_point.y - dy;
            point_in.z = up_point.z + ATAN_I;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         point_ff <= point_in;
         side_ff  <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_point = point_ff;
   assign dn_side  = side_ff;

endmodule

`default_nettype wire

>>> rtl/core/spr_gain.sv
// ----------------------------------------------------------------------------
// spr_gain: CORDIC gain compensation and output register
// Multiplies by 1/K, drops the guard bits rounding half up and saturates to
// the coordinate range. Two register stages; the second drives the output.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_gain import spr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   output logic                      up_ready,
   input  wire point_type            up_point,
   input  wire side_type             up_side,
   output logic                      dn_valid,
   input  wire logic                 dn_ready,
   output logic signed [COORD_W-1:0] dn_lat,
   output logic signed [COORD_W-1:0] dn_long,
   output side_type                  dn_side
);

   localparam int SCALED_W = PROD_W - ROUND_SH;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (ROUND_SH - 1);

   // Product stage
   logic                     valid_a_ff;
   logic                     ready_a;
   logic signed [PROD_W-1:0] px_ff;
   logic signed [PROD_W-1:0] py_ff;
   logic signed [COORD_W-1:0] bx_ff;
   logic signed [COORD_W-1:0] by_ff;
   side_type                 side_a_ff;

   // Output stage
   logic                      valid_b_ff;
   logic signed [COORD_W-1:0] lat_ff;
   logic signed [COORD_W-1:0] long_ff;
   side_type                  side_b_ff;
   logic signed [COORD_W-1:0] lat_in;
   logic signed [COORD_W-1:0] long_in;

   function automatic logic signed [COORD_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W-1:0]   r;
      logic signed [SCALED_W-1:0] s;
      logic signed [COORD_W-1:0]  v;
      r = p + ROUND_HALF;
      s = SCALED_W'(r >>> ROUND_SH);
      if (s > SCALED_W'(COORD_MAX)) begin
         v = COORD_MAX;
      end else if (s < SCALED_W'(COORD_MIN)) begin
         v = COORD_MIN;
      end else begin
         v = COORD_W'(s);
      end
      return v;
   endfunction

   assign ready_a  = !valid_b_ff || dn_ready;
   assign up_ready = !valid_a_ff || ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (up_ready) begin
         valid_a_ff <= up_valid;
      end
   end

   // Multiply by 1/K; keep the unrotated coordinates for the bypass case
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         px_ff     <= PROD_W'(up_point.x) * PROD_W'(INV_GAIN);
         py_ff     <= PROD_W'(up_point.y) * PROD_W'(INV_GAIN);
         bx_ff     <= up_point.x[GUARD +: COORD_W];
         by_ff     <= up_point.y[GUARD +: COORD_W];
         side_a_ff <= up_side;
      end
   end

   // Round, saturate, or pass an unknown radar's point as it came
   always_comb begin
      if (side_a_ff.bypass) begin
         lat_in  = bx_ff;
         long_in = by_ff;
      end else begin
         lat_in  = round_sat(px_ff);
         long_in = round_sat(py_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (ready_a) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && valid_a_ff) begin
         lat_ff    <= lat_in;
         long_ff   <= long_in;
         side_b_ff <= side_a_ff;
      end
   end

   assign dn_valid = valid_b_ff;
   assign dn_lat   = lat_ff;
   assign dn_long  = long_ff;
   assign dn_side  = side_b_ff;

endmodule

`default_nettype wire

>>> rtl/core/sensor_point_rotator.sv
// ----------------------------------------------------------------------------
// sensor_point_rotator: rotates radar points by their radar's mounting angle
// Pipelined CORDIC rotator with per-radar angle registers.
// ----------------------------------------------------------------------------
// The block takes one point per clock while req_tready is high and returns one
// result per point, in order: a register for angle reduction and quadrant turn,
// a registered CORDIC micro-rotation per stage (16 stages by default), then a
// register for the 1/K multiply and one for the rounding with saturation. Every
// stage holds its point when the next one is full, so back-pressure on the
// result side fills the empty stages first and only then lowers req_tready.
// Angles are written as degrees times 64 at csr_addr 1..NUM_RADARS; csr_addr 0
// picks the selected radar. Points from radar number 0 or above NUM_RADARS
// pass unrotated.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_point_rotator import spr_pkg::*; #(
   parameter int NUM_RADARS      = NUM_RADARS_DEF,
   parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Configuration
   input  wire logic                csr_we,
   input  wire logic [CSR_AW-1:0]   csr_addr,
   input  wire logic [CSR_DW-1:0]   csr_wdata,
   // Point requests
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [2*COORD_W-1:0] req_tdata,  // lat_in[19:0], long_in[39:20]
   input  wire logic [RADAR_W-1:0]  req_tuser,   // radar_num[2:0]
   input  wire logic                req_tlast,   // frame_end
   // Rotated points
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [2*COORD_W-1:0]     rsp_tdata,   // lat_out[19:0], long_out[39:20]
   output logic [RADAR_W:0]         rsp_tuser,   // radar_out[2:0], is_selected[3]
   output logic                     rsp_tlast    // frame_last
);

   // Configuration registers
   logic [SEL_W-1:0]        selected_ff;
   logic signed [ANG_W-1:0] angle_ff [NUM_RADARS];

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_ff <= '0;
         for (int i = 0; i < NUM_RADARS; i++) begin
            angle_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_addr == CSR_SELECTED) begin
            selected_ff <= csr_wdata[SEL_W-1:0];
         end
         for (int i = 0; i < NUM_RADARS; i++) begin
            if (csr_addr == CSR_ANGLE_A + CSR_AW'(i)) begin
               angle_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // Angle lookup and side information for the incoming point
   logic signed [ANG_W-1:0] angle_sel;
   side_type                side_req;

   always_comb begin
      angle_sel       = '0;
      side_req.radar  = req_tuser;
      side_req.last   = req_tlast;
      side_req.sel    = (req_tuser != '0) &&
                        ((req_tuser - RADAR_W'(1)) == RADAR_W'(selected_ff));
      side_req.bypass = 1'b1;
      for (int i = 0; i < NUM_RADARS; i++) begin
         if (req_tuser == RADAR_W'(i + 1)) begin
            angle_sel       = angle_ff[i];
            side_req.bypass = 1'b0;
         end
      end
   end

   // Pipeline links: index 0 after pre-rotation, index k after stage k-1
   logic      link_valid [ROTATION_STAGES+1];
   logic      link_ready [ROTATION_STAGES+1];
   point_type link_point [ROTATION_STAGES+1];
   side_type  link_side  [ROTATION_STAGES+1];

   spr_prerot u_prerot (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_angle (angle_sel),
      .up_lat   (req_tdata[COORD_W-1:0]),
      .up_long  (req_tdata[2*COORD_W-1:COORD_W]),
      .up_side  (side_req),
      .dn_valid (link_valid[0]),
      .dn_ready (link_ready[0]),
      .dn_point (link_point[0]),
      .dn_side  (link_side[0])
   );

   for (genvar k = 0; k < ROTATION_STAGES; k++) begin : g_stage
      spr_cordic_stage #(
         .STAGE_IDX (k)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[k]),
         .up_ready (link_ready[k]),
         .up_point (link_point[k]),
         .up_side  (link_side[k]),
         .dn_valid (link_valid[k+1]),
         .dn_ready (link_ready[k+1]),
         .dn_point (link_point[k+1]),
         .dn_side  (link_side[k+1])
      );
   end

   // Gain compensation and output
   logic signed [COORD_W-1:0] lat_res;
   logic signed [COORD_W-1:0] long_res;
   side_type                  side_res;

   spr_gain u_gain (
      .clock    (clock),
      .reset    (reset),
      .up_valid (link_valid[ROTATION_STAGES]),
      .up_ready (link_ready[ROTATION_STAGES]),
      .up_point (link_point[ROTATION_STAGES]),
      .up_side  (link_side[ROTATION_STAGES]),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_lat   (lat_res),
      .dn_long  (long_res),
      .dn_side  (side_res)
   );

   assign rsp_tdata = {long_res, lat_res};
   assign rsp_tuser = {side_res.sel, side_res.radar};
   assign rsp_tlast = side_res.last;

endmodule

`default_nettype wire

>>> test/tb_sensor_point_rotator.sv
// ----------------------------------------------------------------------------
// tb_sensor_point_rotator: self-checking bench of the radar point rotator
// A queued stream driver sends point requests in random bursts. Angle and
// selection registers are rewritten between phases while the pipeline is
// empty. A scoreboard model rotates every accepted point with the same
// fixed-point CORDIC and checks each returned point in order, field by field,
// while the result side stalls on its own random pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sensor_point_rotator;
   timeunit 1ns;
   timeprecision 1ps;
   import spr_pkg::*;

   localparam int NUM_RADARS      = NUM_RADARS_DEF;
   localparam int ROTATION_STAGES = ROTATION_STAGES_DEF;
   localparam int LATENCY         = ROTATION_STAGES + 3;
   localparam int RANDOM_PHASES   = 7;
   localparam int POINTS_PER_PHASE = 72;

   // Register indexes beyond the first angle register
   localparam logic [CSR_AW-1:0] CSR_ANGLE_B = CSR_ANGLE_A + 3'd1;
   localparam logic [CSR_AW-1:0] CSR_ANGLE_C = CSR_ANGLE_A + 3'd2;
   localparam logic [CSR_AW-1:0] CSR_ANGLE_D = CSR_ANGLE_A + 3'd3;
   localparam logic [CSR_AW-1:0] CSR_LAST   = CSR_ANGLE_D;

   localparam logic [RADAR_W-1:0] RADAR_NONE = '0;

   // Radar point as sent in a request
   typedef struct {
      logic [RADAR_W-1:0]        radar;
      logic signed [COORD_W-1:0] lat;
      logic signed [COORD_W-1:0] lng;
      logic                      last;
   } req_point_type;

   // Rotated point as returned
   typedef struct {
      logic signed [COORD_W-1:0] lat;
      logic signed [COORD_W-1:0] lng;
      logic [RADAR_W-1:0]        radar;
      logic                      last;
      logic                      sel;
   } rsp_point_type;

   typedef enum logic [1:0] {RX_OPEN, RX_STALL, RX_CHOPPY} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_AW-1:0]      csr_addr = '0;
   logic [CSR_DW-1:0]      csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [2*COORD_W-1:0]   req_tdata = '0;  // lat_in[19:0], long_in[39:20]
   logic [RADAR_W-1:0]     req_tuser = '0;  // radar_num[2:0]
   logic                   req_tlast = 1'b0; // frame_end
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [2*COORD_W-1:0]   rsp_tdata;       // lat_out[19:0], long_out[39:20]
   logic [RADAR_W:0]       rsp_tuser;       // radar_out[2:0], is_selected[3]
   logic                   rsp_tlast;       // frame_last

   // Scoreboard copy of the registers
   logic [SEL_W-1:0]        sel_radar_m;
   logic signed [ANG_W-1:0] mount_angle [4];

   req_point_type pending_points [$];
   rsp_point_type expected_points [$];
   req_point_type drive_pt;
   req_point_type taken_pt;
   rsp_point_type got_pt;
   rsp_point_type want_pt;

   logic        req_taken = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;

   int errors = 0;
   int n_points = 0;
   int n_checked = 0;
   int n_unrotated = 0;
   int n_frames = 0;
   int n_settings = 0;

   sensor_point_rotator #(
      .NUM_RADARS      (NUM_RADARS),
      .ROTATION_STAGES (ROTATION_STAGES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // atan(2^-i) in 2^-16 degree units
   localparam longint ATAN_STEP [MAX_STAGES] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   // Fixed-point CORDIC rotation of one point by its radar's angle
   function automatic rsp_point_type rotate_point(req_point_type p);
      longint        x, y, z, a, t, dx, dy;
      int            n;
      rsp_point_type r;
      x = p.lat;
      y = p.lng;
      if (p.radar >= 1 && p.radar <= NUM_RADARS) begin
         a = mount_angle[2'(p.radar - 1)];
         if (a >= ANG_HALF) a = a - ANG_FULL;
         if (a < -ANG_HALF) a = a + ANG_FULL;
         // quadrant turn keeps the residual inside +-90 degrees
         if (a > ANG_QUARTER) begin
            t = x; x = -y; y = t; a = a - ANG_QUARTER;
         end else if (a < -ANG_QUARTER) begin
            t = x; x = y; y = -t; a = a + ANG_QUARTER;
         end
         x = x * 256;
         y = y * 256;
         z = a * 1024;
         n = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;
         for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
            end else begin
               x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
            end
         end
         // 1/K gain, guard bits dropped with round half up
         x = (x * INV_GAIN + (64'sd1 <<< 23)) >>> 24;
         y = (y * INV_GAIN + (64'sd1 <<< 23)) >>> 24;
      end
      if (x > COORD_MAX) x = COORD_MAX;
      if (x < COORD_MIN) x = COORD_MIN;
      if (y > COORD_MAX) y = COORD_MAX;
      if (y < COORD_MIN) y = COORD_MIN;
      r.lat   = x[COORD_W-1:0];
      r.lng   = y[COORD_W-1:0];
      r.radar = p.radar;
      r.last  = p.last;
      r.sel   = (p.radar >= 1) && ((p.radar - 1) == sel_radar_m);
      return r;
   endfunction

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Request driver: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            drive_pt = pending_points.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {drive_pt.lng, drive_pt.lat};
            req_tuser  <= drive_pt.radar;
            req_tlast  <= drive_pt.last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Accepted request: predict its rotated point
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         taken_pt.lat   = req_tdata[COORD_W-1:0];
         taken_pt.lng   = req_tdata[2*COORD_W-1:COORD_W];
         taken_pt.radar = req_tuser;
         taken_pt.last  = req_tlast;
         expected_points.push_back(rotate_point(taken_pt));
         n_points = n_points + 1;
         if (taken_pt.radar < 1 || taken_pt.radar > NUM_RADARS) n_unrotated = n_unrotated + 1;
         if (taken_pt.last) n_frames = n_frames + 1;
      end
   end

   // Result side back-pressure: open runs, stall runs and choppy runs
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  rx_mode = RX_OPEN;
                  rx_left = $urandom_range(20, 80);
               end
               1: begin
                  rx_mode = RX_STALL;
                  rx_left = $urandom_range(1, 12);
               end
               default: begin
                  rx_mode = RX_CHOPPY;
                  rx_left = $urandom_range(4, 20);
               end
            endcase
         end
         rx_left = rx_left - 1;
         case (rx_mode)
            RX_OPEN:  rsp_tready <= 1'b1;
            RX_STALL: rsp_tready <= 1'b0;
            default:  rsp_tready <= ($urandom_range(0, 2) != 0);
         endcase
      end
   end

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors = errors + 1;
      end
   endtask

   // Result monitor: compare with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            $error("rotated point returned with no request outstanding");
            errors = errors + 1;
         end else begin
            want_pt = expected_points.pop_front();
            got_pt.lat   = rsp_tdata[COORD_W-1:0];
            got_pt.lng   = rsp_tdata[2*COORD_W-1:COORD_W];
            got_pt.radar = rsp_tuser[RADAR_W-1:0];
            got_pt.sel   = rsp_tuser[RADAR_W];
            got_pt.last  = rsp_tlast;
            check_field("lat_out", want_pt.lat, got_pt.lat);
            check_field("long_out", want_pt.lng, got_pt.lng);
            check_field("radar_out", want_pt.radar, got_pt.radar);
            check_field("frame_last", want_pt.last, got_pt.last);
            check_field("is_selected", want_pt.sel, got_pt.sel);
            n_checked = n_checked + 1;
         end
      end
   end

   // Wait until the pipeline has drained and every expected point has returned
   task automatic wait_idle();
      while (pending_points.size() != 0 || req_tvalid || expected_points.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One register write; write enable stays up for back-to-back writes
   task automatic write_csr(input logic [CSR_AW-1:0] idx, input longint value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CSR_DW-1:0];
      @(posedge clock);
      if (idx == CSR_SELECTED)
         sel_radar_m = value[SEL_W-1:0];
      else if (idx <= CSR_LAST)
         mount_angle[2'(idx - CSR_ANGLE_A)] = value[ANG_W-1:0];
   endtask

   // New register setting, written while the pipeline is empty
   task automatic load_setting(input int sel, input int ang_a, input int ang_b,
                               input int ang_c, input int ang_d);
      wait_idle();
      write_csr(CSR_SELECTED, sel);
      write_csr(CSR_ANGLE_A, ang_a);
      write_csr(CSR_ANGLE_B, ang_b);
      write_csr(CSR_ANGLE_C, ang_c);
      write_csr(CSR_ANGLE_D, ang_d);
      @(negedge clock);
      csr_we <= 1'b0;
      n_settings = n_settings + 1;
   endtask

   task automatic add_point(input int radar, input int lat, input int lng, input bit last);
      req_point_type p;
      p.radar = radar[RADAR_W-1:0];
      p.lat   = lat[COORD_W-1:0];
      p.lng   = lng[COORD_W-1:0];
      p.last  = last;
      pending_points.push_back(p);
   endtask

   function automatic int rand_coord();
      int v;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 8192) - 4096;
         1: begin
            case ($urandom_range(0, 3))
               0: v = COORD_MAX;
               1: v = COORD_MIN;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: v = $signed($urandom) >>> 12;
      endcase
      return v;
   endfunction

   function automatic int rand_angle();
      int v;
      case ($urandom_range(0, 7))
         0: v = ANG_HALF;
         1: v = -ANG_HALF;
         2: v = ($urandom_range(0, 1) == 0) ? ANG_QUARTER : -ANG_QUARTER;
         3: v = ($urandom_range(0, 1) == 0) ? ANG_QUARTER + 1 : -ANG_QUARTER - 1;
         default: v = $urandom_range(0, 2 * ANG_HALF) - ANG_HALF;
      endcase
      return v;
   endfunction

   function automatic int rand_radar();
      int r;
      if ($urandom_range(0, 11) == 0) begin
         r = $urandom_range(0, 3);
         r = (r == 0) ? RADAR_NONE : NUM_RADARS + r;
      end else begin
         r = $urandom_range(1, NUM_RADARS);
      end
      return r;
   endfunction

   // Main sequence
   initial begin
      int ext [4];
      ext = '{COORD_MAX, COORD_MIN, 0, -1};
      sel_radar_m = '0;
      for (int i = 0; i < 4; i++) mount_angle[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset setting: zero angles, every radar number, coordinate extremes
      for (int rn = 0; rn < 8; rn++)
         add_point(rn, ext[rn % 4], ext[(rn + 1) % 4], rn[0]);

      // Half-turn and quarter-turn boundaries
      load_setting(3, ANG_HALF, -ANG_HALF, ANG_QUARTER, -ANG_QUARTER);
      for (int rn = 1; rn <= NUM_RADARS; rn++) begin
         add_point(rn, COORD_MAX, COORD_MIN, 1'b0);
         add_point(rn, 1000, -3000, rn == NUM_RADARS);
      end

      // Just past a quarter turn, 45 degrees (saturating) and just under
      // a half turn; writes to unused indexes must leave the angles alone
      load_setting(1, ANG_QUARTER + 1, -ANG_QUARTER - 1, 2880, ANG_HALF - 1);
      for (logic [CSR_AW-1:0] idx = CSR_LAST + CSR_AW'(1); idx != 0; idx++)
         write_csr(idx, $urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      for (int rn = 1; rn <= NUM_RADARS; rn++) begin
         add_point(rn, COORD_MAX, COORD_MAX, 1'b0);
         add_point(rn, COORD_MIN, -1, 1'b1);
      end
      add_point(RADAR_NONE, COORD_MIN, COORD_MAX, 1'b1);

      // Random settings with random frames of random points
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         load_setting($urandom_range(0, 3), rand_angle(), rand_angle(),
                      rand_angle(), rand_angle());
         for (int k = 0; k < POINTS_PER_PHASE; k++)
            add_point(rand_radar(), rand_coord(), rand_coord(), $urandom_range(0, 7) == 0);
      end

      wait_idle();
      if (expected_points.size() != 0) begin
         $error("%0d rotated points never returned", expected_points.size());
         errors = errors + 1;
      end
      $display("Run covered %0d points (%0d unknown radar, %0d frame ends) under %0d settings.",
               n_points, n_unrotated, n_frames, n_settings + 1);
      $display("Checked %0d rotated points, %0d mismatches.", n_checked, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(5_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
